// File: hw/rtl/pnas_pkg.sv
// Package for the pack node-ID authorization sequencer.
// Holds phase codes, function codes and the item/result structs; no dependencies.
package pnas_pkg;

  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_FRAME = 3'd1;
  localparam logic [2:0] FUNC_SNRD  = 3'd2;
  localparam logic [2:0] FUNC_START = 3'd3;
  localparam logic [2:0] FUNC_FIRST = 3'd4;

  localparam logic [3:0] PH_IDLE           = 4'd0;
  localparam logic [3:0] PH_WAIT_REQUEST   = 4'd1;
  localparam logic [3:0] PH_START          = 4'd2;
  localparam logic [3:0] PH_SLAVE_SELECT   = 4'd3;
  localparam logic [3:0] PH_SELECT_CONFIRM = 4'd4;
  localparam logic [3:0] PH_WAIT_CONFIRM   = 4'd5;
  localparam logic [3:0] PH_AUTH_START     = 4'd6;
  localparam logic [3:0] PH_AUTHORIZING    = 4'd7;
  localparam logic [3:0] PH_VERIFY         = 4'd8;
  localparam logic [3:0] PH_ASSIGNED       = 4'd9;
  localparam logic [3:0] PH_FAILURE        = 4'd10;
  localparam logic [3:0] PH_WAIT_DESELECT  = 4'd11;

  localparam logic [1:0] SEND_NONE  = 2'd0;
  localparam logic [1:0] SEND_EMPTY = 2'd1;
  localparam logic [1:0] SEND_BYTE  = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_OK   = 2'd1;
  localparam logic [1:0] EV_FAIL = 2'd2;

  localparam logic [2:0] CFG_STEP     = 3'd0;
  localparam logic [2:0] CFG_AUTH     = 3'd1;
  localparam logic [2:0] CFG_DESELECT = 3'd2;
  localparam logic [2:0] CFG_SETTLE   = 3'd3;
  localparam logic [2:0] CFG_OFFSET   = 3'd4;
  localparam logic [2:0] CFG_FRAME_ID = 3'd5;

  // classified item handed from front to back
  typedef struct packed {
    logic       is_tick;
    logic       is_frame_hit;   // frame with matching identifier
    logic       is_snrd;        // serial-read completion that targets a serial read
    logic       snrd_any;
    logic       is_start;
    logic       is_first;
    logic [4:0] pack_id;
    logic       cmd_ok;
    logic [7:0] can_byte0;
    logic       select_ok;
    logic       deselect_ok;
    logic       soc_known;
  } pnas_item_t;

  typedef struct packed {
    logic [1:0] send_kind;
    logic [7:0] send_byte;
    logic       read_sn_req;
    logic       select_req;
    logic [4:0] select_pack;
    logic       deselect_req;
    logic [4:0] deselect_pack;
    logic [1:0] event_res;
    logic [4:0] event_pack;
    logic       busy_res;
    logic       step_error;
  } pnas_res_t;

endpackage

// File: hw/rtl/pnas_fifo.sv
// Small two-entry queue with full/empty flags.
// Generic over payload width; no package dependency.
module pnas_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n) !(full && empty))
    else $error("queue full and empty");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full) else $error("full queue lost an entry");
endmodule

// File: hw/rtl/pnas_front.sv
// Front end: decodes and classifies input items against the frame-id register.
// Depends on pnas_pkg.
module pnas_front import pnas_pkg::*; (
  input  logic [2:0]  func,
  input  logic [4:0]  pack_id,
  input  logic        cmd_pack_any,
  input  logic        cmd_is_read_sn,
  input  logic        cmd_ok,
  input  logic [10:0] can_id,
  input  logic [7:0]  can_byte0,
  input  logic        select_ok,
  input  logic        deselect_ok,
  input  logic        soc_known,
  input  logic [10:0] frame_id,
  output pnas_item_t  item
);
  always_comb begin
    item              = '0;
    item.is_tick      = func == FUNC_TICK;
    item.is_frame_hit = (func == FUNC_FRAME) && (can_id == frame_id);
    item.is_snrd      = (func == FUNC_SNRD) && cmd_is_read_sn;
    item.snrd_any     = cmd_pack_any;
    item.is_start     = func == FUNC_START;
    item.is_first     = func == FUNC_FIRST;
    item.pack_id      = pack_id;
    item.cmd_ok       = cmd_ok;
    item.can_byte0    = can_byte0;
    item.select_ok    = select_ok;
    item.deselect_ok  = deselect_ok;
    item.soc_known    = soc_known;
  end
endmodule

// File: hw/rtl/pnas_back.sv
// Back end: phase machine, countdown and result forming for one pack.
// Depends on pnas_pkg.
module pnas_back import pnas_pkg::*; #(
  parameter int PACK_ID_WIDTH = 5,
  parameter int TIMER_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  pnas_item_t  item,
  input  logic [15:0] step_to,
  input  logic [15:0] auth_to,
  input  logic [15:0] desel_to,
  input  logic [15:0] settle_to,
  input  logic [6:0]  offset,
  output pnas_res_t   res
);
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  logic [3:0]               phase_r, phase_nxt;
  logic [PACK_ID_WIDTH-1:0] pack_r, pack_nxt, ip;
  logic                     valid_r, valid_nxt, first_r, first_nxt;
  logic [TIMER_WIDTH-1:0]   left_r, left_nxt, per_r, per_nxt, dec;
  logic [7:0]               nbyte;

  function automatic logic [TIMER_WIDTH-1:0] sat(input logic [15:0] v);
    logic [31:0] w;
    w = {16'd0, v};
    if (w > {{(32-TIMER_WIDTH){1'b0}}, TMAX}) return TMAX;
    return w[TIMER_WIDTH-1:0];
  endfunction

  function automatic logic [4:0] p5(input logic [PACK_ID_WIDTH-1:0] p);
    logic [7:0] w;
    w = 8'(p);
    return w[4:0];
  endfunction

  assign ip    = PACK_ID_WIDTH'(item.pack_id);
  assign nbyte = 8'(pack_r) + {1'b0, offset};
  assign dec   = (left_r != '0) ? left_r - 1'b1 : left_r;

  always_comb begin
    phase_nxt = phase_r; pack_nxt = pack_r; valid_nxt = valid_r;
    first_nxt = first_r; left_nxt = left_r; per_nxt = per_r;
    res = '0;
    if (item.is_tick) begin
      left_nxt = dec;
      if (!valid_r) res.step_error = 1'b1;
      else begin
        unique case (phase_r)
          PH_WAIT_REQUEST, PH_SLAVE_SELECT, PH_WAIT_CONFIRM:
            if (dec == '0) phase_nxt = PH_FAILURE;
          PH_START: begin
            res.deselect_req = 1'b1; res.deselect_pack = p5(pack_r);
            if (!item.deselect_ok) phase_nxt = PH_FAILURE;
            else if (dec == '0) begin
              res.send_kind = SEND_EMPTY; phase_nxt = PH_SLAVE_SELECT;
              left_nxt = sat(step_to); per_nxt = sat(step_to);
            end
          end
          PH_SELECT_CONFIRM: begin
            res.send_kind = SEND_BYTE; res.send_byte = nbyte;
            left_nxt = per_r; phase_nxt = PH_WAIT_CONFIRM;
          end
          PH_AUTH_START: begin
            res.select_req = 1'b1; res.select_pack = p5(pack_r);
            if (!item.select_ok) phase_nxt = PH_FAILURE;
            else if (dec == '0) begin
              res.read_sn_req = 1'b1; phase_nxt = PH_AUTHORIZING;
              left_nxt = sat(auth_to); per_nxt = sat(auth_to);
            end
          end
          PH_AUTHORIZING:
            if (dec == '0) begin phase_nxt = PH_FAILURE; res.step_error = 1'b1; end
          PH_VERIFY:
            if (dec == '0) begin phase_nxt = PH_FAILURE; res.step_error = 1'b1; end
            else if (first_r || item.soc_known) phase_nxt = PH_ASSIGNED;
          PH_ASSIGNED: begin
            res.event_res = EV_OK; res.event_pack = p5(pack_r);
            valid_nxt = 1'b0; pack_nxt = '0; first_nxt = 1'b0; phase_nxt = PH_IDLE;
            left_nxt = sat(step_to); per_nxt = sat(step_to);
          end
          PH_FAILURE: begin
            res.deselect_req = 1'b1; res.deselect_pack = p5(pack_r);
            if (item.deselect_ok) begin
              left_nxt = sat(first_r ? settle_to : desel_to);
              per_nxt = left_nxt; phase_nxt = PH_WAIT_DESELECT;
            end
          end
          PH_WAIT_DESELECT:
            if (dec == '0) begin
              res.event_res = EV_FAIL; res.event_pack = p5(pack_r);
              valid_nxt = 1'b0; pack_nxt = '0; first_nxt = 1'b0; phase_nxt = PH_IDLE;
              left_nxt = sat(step_to); per_nxt = sat(step_to);
            end
          default: ;
        endcase
      end
    end else if (item.is_frame_hit && valid_r) begin
      if (phase_r == PH_WAIT_REQUEST) begin
        phase_nxt = PH_START; left_nxt = sat(settle_to); per_nxt = sat(settle_to);
      end else if (phase_r == PH_SLAVE_SELECT) phase_nxt = PH_SELECT_CONFIRM;
      else if (phase_r == PH_WAIT_CONFIRM && item.can_byte0 == nbyte) begin
        phase_nxt = PH_AUTH_START; left_nxt = sat(settle_to); per_nxt = sat(settle_to);
      end
    end else if (item.is_snrd && valid_r && (item.snrd_any || ip == pack_r)) begin
      if (item.cmd_ok) begin
        phase_nxt = PH_VERIFY; left_nxt = sat(auth_to); per_nxt = sat(auth_to);
      end else phase_nxt = PH_FAILURE;
    end else if (item.is_start || item.is_first) begin
      if (valid_r) begin res.deselect_req = 1'b1; res.deselect_pack = p5(pack_r); end
      valid_nxt = 1'b1; pack_nxt = ip; first_nxt = item.is_first;
      left_nxt = sat(step_to); per_nxt = sat(step_to);
      if (item.is_first) phase_nxt = PH_AUTH_START;
      else begin
        res.select_req = 1'b1; res.select_pack = p5(ip);
        if (!item.select_ok) begin
          res.event_res = EV_FAIL; res.event_pack = p5(ip); res.step_error = 1'b1;
          valid_nxt = 1'b0; pack_nxt = '0; first_nxt = 1'b0; phase_nxt = PH_IDLE;
        end else phase_nxt = PH_WAIT_REQUEST;
      end
    end
    res.busy_res = valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; pack_r <= '0; valid_r <= 1'b0; first_r <= 1'b0;
      left_r <= sat(16'd500); per_r <= sat(16'd500);
    end else if (go) begin
      phase_r <= phase_nxt; pack_r <= pack_nxt; valid_r <= valid_nxt;
      first_r <= first_nxt; left_r <= left_nxt; per_r <= per_nxt;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> (phase_r == PH_IDLE && pack_r == '0)) else $error("stale pack");
  a_left_le_per: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.is_tick && valid_r && phase_r == PH_SELECT_CONFIRM) |=> left_r == per_r)
    else $error("reload mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(phase_r)) else $error("phase moved without item");
endmodule

// File: hw/rtl/pack_node_id_auth_sequencer.sv
// Channel  | ports                       | accepted when
// input    | in_push/in_full, in_*       | in_push && !in_full
// result   | out_pop/out_empty, out_*    | out_pop && !out_empty
// config   | cfg_valid/cfg_ready, index  | cfg_valid && cfg_ready
// One item per cycle while the result queue is not full: the phase machine updates in the accept cycle and the
// result enters a two-entry result queue; full only when both entries wait.
// Synchronous reset restores register defaults and idle phase.
// Depends on pnas_pkg, pnas_front, pnas_back, pnas_fifo.
module pack_node_id_auth_sequencer import pnas_pkg::*; #(
  parameter int PACK_ID_WIDTH = 5,
  parameter int TIMER_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_func,
  input  logic [4:0]  in_pack_id,
  input  logic        in_cmd_pack_any,
  input  logic        in_cmd_is_read_sn,
  input  logic        in_cmd_ok,
  input  logic [10:0] in_can_id,
  input  logic [7:0]  in_can_byte0,
  input  logic        in_select_ok,
  input  logic        in_deselect_ok,
  input  logic        in_soc_known,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_send_kind,
  output logic [7:0]  out_send_byte,
  output logic        out_read_sn_req,
  output logic        out_select_req,
  output logic [4:0]  out_select_pack,
  output logic        out_deselect_req,
  output logic [4:0]  out_deselect_pack,
  output logic [1:0]  out_event_res,
  output logic [4:0]  out_event_pack,
  output logic        out_busy_res,
  output logic        out_step_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] step_r, auth_r, desel_r, settle_r;
  logic [6:0]  off_r;
  logic [10:0] fid_r;
  pnas_item_t  item;
  pnas_res_t   res, qres;
  logic        go;

  assign cfg_ready = 1'b1;
  assign go = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 16'd500; auth_r <= 16'd3000; desel_r <= 16'd3000;
      settle_r <= 16'd50; off_r <= 7'd5; fid_r <= 11'h70;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STEP:     step_r   <= cfg_data;
        CFG_AUTH:     auth_r   <= cfg_data;
        CFG_DESELECT: desel_r  <= cfg_data;
        CFG_SETTLE:   settle_r <= cfg_data;
        CFG_OFFSET:   off_r    <= cfg_data[6:0];
        CFG_FRAME_ID: fid_r    <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  pnas_front u_front (
    .func(in_func), .pack_id(in_pack_id), .cmd_pack_any(in_cmd_pack_any),
    .cmd_is_read_sn(in_cmd_is_read_sn), .cmd_ok(in_cmd_ok), .can_id(in_can_id),
    .can_byte0(in_can_byte0), .select_ok(in_select_ok), .deselect_ok(in_deselect_ok),
    .soc_known(in_soc_known), .frame_id(fid_r), .item(item)
  );

  pnas_back #(.PACK_ID_WIDTH(PACK_ID_WIDTH), .TIMER_WIDTH(TIMER_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .go(go), .item(item), .step_to(step_r),
    .auth_to(auth_r), .desel_to(desel_r), .settle_to(settle_r), .offset(off_r),
    .res(res)
  );

  pnas_fifo #(.W($bits(pnas_res_t))) u_q (
    .clk(clk), .rst_n(rst_n), .push(go), .wdata(res), .full(in_full),
    .pop(out_pop), .rdata(qres), .empty(out_empty)
  );

  assign out_send_kind     = qres.send_kind;
  assign out_send_byte     = qres.send_byte;
  assign out_read_sn_req   = qres.read_sn_req;
  assign out_select_req    = qres.select_req;
  assign out_select_pack   = qres.select_pack;
  assign out_deselect_req  = qres.deselect_req;
  assign out_deselect_pack = qres.deselect_pack;
  assign out_event_res     = qres.event_res;
  assign out_event_pack    = qres.event_pack;
  assign out_busy_res      = qres.busy_res;
  assign out_step_error    = qres.step_error;
endmodule
